FILE: design/lca_pkg.sv
`timescale 1ns / 1ps
package lca_pkg;

  localparam int CNT_W  = 31;
  localparam int SUM_W  = 40;
  localparam int RES_W  = 24;
  localparam int SIZE_W = 11;
  localparam int LBL_W  = 10;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 24;
  localparam int PROD_W = 64;
  localparam int HALF_W = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [ACT_W-1:0] ACT_ACC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd3;

  localparam logic [CIDX_W-1:0] REG_SIZE_X      = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SIZE_Y      = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SIZE_Z      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_RES_X       = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RES_Y       = 3'd4;
  localparam logic [CIDX_W-1:0] REG_RES_Z       = 3'd5;
  localparam logic [CIDX_W-1:0] REG_LABEL_COUNT = 3'd6;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [SUM_W-1:0] sz;
  } entry_t;

  typedef struct packed {
    logic [LBL_W-1:0]  label;
    logic [STAT_W-1:0] status;
    entry_t            ent;
  } qcmd_t;

  typedef struct packed {
    logic [LBL_W-1:0]  label;
    logic [SUM_W-1:0]  cx;
    logic [SUM_W-1:0]  cy;
    logic [SUM_W-1:0]  cz;
    logic [CNT_W-1:0]  total;
    logic [STAT_W-1:0] status;
  } qres_t;

  typedef enum logic {
    CS_CLEAR,
    CS_RUN
  } ctl_state_t;

  typedef enum logic [2:0] {
    QS_IDLE,
    QS_MUL,
    QS_ADD,
    QS_DIV,
    QS_DONE
  } q_state_t;

endpackage

FILE: design/lca_ram.sv
`timescale 1ns / 1ps
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lca_query.sv
`timescale 1ns / 1ps
module lca_query import lca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  qcmd_t            cmd,
  input  logic [RES_W-1:0] res_x,
  input  logic [RES_W-1:0] res_y,
  input  logic [RES_W-1:0] res_z,
  output logic             busy,
  output logic             res_valid,
  input  logic             res_ready,
  output qres_t            res
);

  q_state_t state, state_next;

  logic [1:0]              axis;
  logic [5:0]              bitcnt;
  logic [RES_W+HALF_W-1:0] p_hi;
  logic [RES_W+HALF_W-1:0] p_lo;
  logic [PROD_W-1:0]       dvd;
  logic [CNT_W-1:0]        rem;
  qcmd_t                   cur;
  logic [SUM_W-1:0]        cx, cy, cz;

  logic [RES_W-1:0] res_sel;
  logic [SUM_W-1:0] sum_sel;
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [CNT_W:0]   rem_sub;
  logic [PROD_W-1:0] quo;
  logic [SUM_W-1:0] quo_sat;

  always_comb begin
    case (axis)
      2'd0:    begin res_sel = res_x; sum_sel = cur.ent.sx; end
      2'd1:    begin res_sel = res_y; sum_sel = cur.ent.sy; end
      default: begin res_sel = res_z; sum_sel = cur.ent.sz; end
    endcase
  end

  assign rem_sh  = {rem, dvd[PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, cur.ent.cnt};
  assign rem_sub = rem_sh - {1'b0, cur.ent.cnt};
  assign quo     = {dvd[PROD_W-2:0], ge};
  assign quo_sat = (|quo[PROD_W-1:SUM_W]) ? SUM_MAX : quo[SUM_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      QS_IDLE: if (start) state_next = (cmd.status == STAT_OK) ? QS_MUL : QS_DONE;
      QS_MUL:  state_next = QS_ADD;
      QS_ADD:  state_next = QS_DIV;
      QS_DIV:  if (bitcnt == 6'd63) state_next = (axis == 2'd2) ? QS_DONE : QS_MUL;
      QS_DONE: if (res_ready) state_next = QS_IDLE;
      default: state_next = QS_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    res_valid = 1'b0;
    case (state)
      QS_IDLE: busy = 1'b0;
      QS_DONE: res_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= QS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      QS_IDLE: begin
        cur    <= cmd;
        axis   <= 2'd0;
        cx     <= '0;
        cy     <= '0;
        cz     <= '0;
      end
      QS_MUL: begin
        p_hi <= res_sel * sum_sel[SUM_W-1:HALF_W];
        p_lo <= res_sel * sum_sel[HALF_W-1:0];
      end
      QS_ADD: begin
        dvd    <= (PROD_W'(p_hi) << HALF_W) + PROD_W'(p_lo);
        rem    <= '0;
        bitcnt <= '0;
      end
      QS_DIV: begin
        dvd    <= quo;
        rem    <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        bitcnt <= bitcnt + 6'd1;
        if (bitcnt == 6'd63) begin
          case (axis)
            2'd0:    cx <= quo_sat;
            2'd1:    cy <= quo_sat;
            default: cz <= quo_sat;
          endcase
          axis <= axis + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.label  = cur.label;
    res.cx     = cx;
    res.cy     = cy;
    res.cz     = cz;
    res.total  = (cur.status == STAT_OK) ? cur.ent.cnt : '0;
    res.status = cur.status;
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == QS_DONE && !res_ready) |=> state == QS_DONE)
    else $error("query result dropped");
  a_no_div_on_empty: assert property (@(posedge clk) disable iff (rst)
    (state == QS_DIV) |-> (cur.ent.cnt != '0))
    else $error("division by zero count");
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    (state == QS_MUL) |-> (axis != 2'd3))
    else $error("axis overrun");

endmodule

FILE: design/label_centroid_accumulator.sv
`timescale 1ns / 1ps
// Label centroid accumulator.
// item channel (item_valid/item_ready, action, label) takes one word per voxel
// label in raster order (x fastest), a query or a clear. result channel
// (result_valid/result_ready) gives one word per query. cfg channel writes the
// size, resolution and label count registers; it is always ready.
// Accumulate: one word per cycle while no clear pass or query holds the item
// channel; the store is read in the cycle the word is taken and written back
// the next, with forwarding from the last write for repeated labels.
// Query: the entry is read, then x, y and z are each multiplied (states QS_MUL
// and QS_ADD) and divided by the count with a shared 1 bit/cycle divider; a
// query that is empty, out of range or label zero skips both. No item word is
// taken from a query's acceptance until its result has left the query unit.
// Clear, and reset: a pass zeroes all MAX_LABELS entries of the store, one
// entry a cycle, during which no item word is taken.
// The result sits in an output register; further accumulates are taken while
// it waits, and a further query is held in the query unit until that is taken.
module label_centroid_accumulator import lca_pkg::*; #(
  parameter int MAX_LABELS = 1024,
  parameter int MAX_DIM    = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [LBL_W-1:0]  label,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [LBL_W-1:0]  out_label,
  output logic [SUM_W-1:0]  centroid_x,
  output logic [SUM_W-1:0]  centroid_y,
  output logic [SUM_W-1:0]  centroid_z,
  output logic [CNT_W-1:0]  voxel_total,
  output logic [STAT_W-1:0] status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_data
);

  localparam int LAW = $clog2(MAX_LABELS);
  localparam int LXW = (LAW > LBL_W) ? LAW : LBL_W;
  localparam int LCW = ($clog2(MAX_LABELS + 1) > SIZE_W) ? $clog2(MAX_LABELS + 1) : SIZE_W;
  localparam int DW  = $clog2(MAX_DIM);
  localparam int EW  = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;
  localparam int EWD = $bits(entry_t);

  function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [EW-1:0] e;
    e = EW'(s);
    if (s == '0) e = EW'(1);
    else if (e > EW'(MAX_DIM)) e = EW'(MAX_DIM);
    return e;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [DW-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  logic [SIZE_W-1:0] size_x, size_y, size_z, label_count;
  logic [RES_W-1:0]  res_x, res_y, res_z;

  ctl_state_t cstate, cstate_next;
  logic [LAW-1:0] sweep_ptr;
  logic           sweep_we;
  logic           run_ok;

  logic [DW-1:0]  pos_x, pos_y, pos_z;
  logic [DW-1:0]  pos_x_next, pos_y_next, pos_z_next;

  logic [LXW-1:0] lbl_x;
  logic [LAW-1:0] lbl_addr;
  logic [LCW-1:0] eff_lbl;
  logic           in_range;
  logic           item_acc, acc_go, query_go, clear_go;

  logic           s1_valid, s1_query, s1_range;
  logic [LAW-1:0] s1_addr;
  logic [LBL_W-1:0] s1_label;
  logic [DW-1:0]  s1_px, s1_py, s1_pz;

  logic           fwd_valid;
  logic [LAW-1:0] fwd_addr;
  entry_t         fwd_data;

  logic [EWD-1:0] ram_rdata;
  entry_t         cur, upd;
  logic           acc_we;
  logic           ram_we;
  logic [LAW-1:0] ram_waddr;
  entry_t         ram_wdata;

  qcmd_t          qcmd;
  logic           q_start, q_busy, q_valid, q_ready;
  qres_t          qres;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= SIZE_W'(1);
      size_y      <= SIZE_W'(1);
      size_z      <= SIZE_W'(1);
      res_x       <= RES_W'(65536);
      res_y       <= RES_W'(65536);
      res_z       <= RES_W'(65536);
      label_count <= SIZE_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X:      size_x      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:      size_y      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:      size_z      <= cfg_data[SIZE_W-1:0];
        REG_RES_X:       res_x       <= cfg_data;
        REG_RES_Y:       res_y       <= cfg_data;
        REG_RES_Z:       res_z       <= cfg_data;
        REG_LABEL_COUNT: label_count <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_comb begin
    cstate_next = cstate;
    case (cstate)
      CS_CLEAR: if (sweep_we && sweep_ptr == LAW'(MAX_LABELS - 1)) cstate_next = CS_RUN;
      CS_RUN:   if (clear_go) cstate_next = CS_CLEAR;
      default:  cstate_next = CS_CLEAR;
    endcase
  end

  always_comb begin
    sweep_we = 1'b0;
    run_ok   = 1'b0;
    case (cstate)
      CS_CLEAR: sweep_we = !acc_we;
      CS_RUN:   run_ok   = 1'b1;
      default:  sweep_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate    <= CS_CLEAR;
      sweep_ptr <= '0;
    end else begin
      cstate <= cstate_next;
      if (clear_go) sweep_ptr <= '0;
      else if (sweep_we) sweep_ptr <= sweep_ptr + LAW'(1);
    end
  end

  assign item_ready = run_ok && !q_busy && !(s1_valid && s1_query);
  assign item_acc   = item_valid && item_ready;
  assign acc_go     = item_acc && action == ACT_ACC;
  assign query_go   = item_acc && action == ACT_QUERY;
  assign clear_go   = item_acc && action == ACT_CLEAR;

  assign lbl_x    = LXW'(label);
  assign lbl_addr = lbl_x[LAW-1:0];
  assign eff_lbl  = (LCW'(label_count) < LCW'(MAX_LABELS)) ? LCW'(label_count)
                                                           : LCW'(MAX_LABELS);
  assign in_range = LCW'(label) < eff_lbl;

  // raster position
  always_comb begin
    logic [EW-1:0] nx, ny, nz;
    nx = EW'(pos_x) + EW'(1);
    ny = EW'(pos_y) + EW'(1);
    nz = EW'(pos_z) + EW'(1);
    pos_x_next = DW'(nx);
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    if (nx >= eff_size(size_x)) begin
      pos_x_next = '0;
      pos_y_next = DW'(ny);
      if (ny >= eff_size(size_y)) begin
        pos_y_next = '0;
        pos_z_next = (nz >= eff_size(size_z)) ? '0 : DW'(nz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_go) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (acc_go) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc_go || query_go;
    end
    s1_query <= query_go;
    s1_range <= in_range;
    s1_addr  <= lbl_addr;
    s1_label <= label;
    s1_px    <= pos_x;
    s1_py    <= pos_y;
    s1_pz    <= pos_z;
  end

  lca_ram #(.WIDTH(EWD), .DEPTH(MAX_LABELS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (lbl_addr),
    .rdata (ram_rdata)
  );

  // modify and write back
  assign cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : entry_t'(ram_rdata);

  always_comb begin
    upd.cnt = cur.cnt + CNT_W'(1);
    upd.sx  = sat_add(cur.sx, s1_px);
    upd.sy  = sat_add(cur.sy, s1_py);
    upd.sz  = sat_add(cur.sz, s1_pz);
  end

  assign acc_we    = s1_valid && !s1_query && s1_range && cur.cnt != CNT_MAX;
  assign ram_we    = acc_we || sweep_we;
  assign ram_waddr = acc_we ? s1_addr : sweep_ptr;
  assign ram_wdata = acc_we ? upd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= acc_we;
    end
    fwd_addr <= s1_addr;
    fwd_data <= upd;
  end

  // query
  always_comb begin
    qcmd.label = s1_label;
    qcmd.ent   = cur;
    if (!s1_range)             qcmd.status = STAT_RANGE;
    else if (s1_label == '0)   qcmd.status = STAT_ZERO;
    else if (cur.cnt == '0)    qcmd.status = STAT_EMPTY;
    else                       qcmd.status = STAT_OK;
  end

  assign q_start = s1_valid && s1_query;

  lca_query u_query (
    .clk       (clk),
    .rst       (rst),
    .start     (q_start),
    .cmd       (qcmd),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .busy      (q_busy),
    .res_valid (q_valid),
    .res_ready (q_ready),
    .res       (qres)
  );

  // output register
  assign q_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_ready) begin
      result_valid <= q_valid;
    end
    if (q_valid && q_ready) begin
      out_label   <= qres.label;
      centroid_x  <= qres.cx;
      centroid_y  <= qres.cy;
      centroid_z  <= qres.cz;
      voxel_total <= qres.total;
      status      <= qres.status;
    end
  end

  a_take_in_run: assert property (@(posedge clk) disable iff (rst)
    item_acc |-> cstate == CS_RUN)
    else $error("word taken during clear pass");
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> !sweep_we)
    else $error("store write collision");
  a_clear_enters: assert property (@(posedge clk) disable iff (rst)
    clear_go |=> cstate == CS_CLEAR && !item_ready)
    else $error("clear not started");
  a_query_idle: assert property (@(posedge clk) disable iff (rst)
    q_start |-> !q_busy)
    else $error("query started while divider busy");

endmodule

FILE: verif/centroid_checker.sv
`timescale 1ns / 1ps
module centroid_checker import lca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [LBL_W-1:0]  label,
  input  logic              result_valid,
  input  logic              result_ready,
  input  logic [LBL_W-1:0]  out_label,
  input  logic [SUM_W-1:0]  centroid_x,
  input  logic [SUM_W-1:0]  centroid_y,
  input  logic [SUM_W-1:0]  centroid_z,
  input  logic [CNT_W-1:0]  voxel_total,
  input  logic [STAT_W-1:0] status,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending
);

  localparam int NLBL = 1024;
  localparam int NDIM = 1024;

  logic [SIZE_W-1:0] sz_x, sz_y, sz_z, lbl_lim;
  logic [RES_W-1:0]  rs_x, rs_y, rs_z;
  logic [CNT_W-1:0]  cnt_mem [NLBL];
  logic [SUM_W-1:0]  sx_mem [NLBL];
  logic [SUM_W-1:0]  sy_mem [NLBL];
  logic [SUM_W-1:0]  sz_mem [NLBL];
  logic [9:0]        px, py, pz;
  qres_t             centroid_q [$];

  function automatic int eff_dim(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > NDIM) return NDIM;
    return int'(s);
  endfunction

  function automatic logic [SUM_W-1:0] scaled_mean(logic [RES_W-1:0] r,
      logic [SUM_W-1:0] s, logic [CNT_W-1:0] c);
    logic [PROD_W-1:0] q;
    q = (64'(r) * 64'(s)) / 64'(c);
    return (q > 64'(SUM_MAX)) ? SUM_MAX : q[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [9:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + (SUM_W + 1)'(b);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  task automatic wipe_store();
    for (int i = 0; i < NLBL; i++) begin
      cnt_mem[i] = '0; sx_mem[i] = '0; sy_mem[i] = '0; sz_mem[i] = '0;
    end
    px = 0; py = 0; pz = 0;
  endtask

  task automatic predict_word(logic [ACT_W-1:0] a, logic [LBL_W-1:0] l);
    qres_t r;
    int lim;
    bit ok;
    lim = (lbl_lim < NLBL) ? int'(lbl_lim) : NLBL;
    ok = l < lim;
    if (a == ACT_ACC) begin
      if (ok && cnt_mem[l] != CNT_MAX) begin
        cnt_mem[l]++;
        sx_mem[l] = sat_sum(sx_mem[l], px);
        sy_mem[l] = sat_sum(sy_mem[l], py);
        sz_mem[l] = sat_sum(sz_mem[l], pz);
      end
      if (int'(px) + 1 >= eff_dim(sz_x)) begin
        px = 0;
        if (int'(py) + 1 >= eff_dim(sz_y)) begin
          py = 0;
          pz = (int'(pz) + 1 >= eff_dim(sz_z)) ? 10'd0 : pz + 10'd1;
        end else py++;
      end else px++;
    end else if (a == ACT_CLEAR) begin
      wipe_store();
    end else if (a == ACT_QUERY) begin
      r = '0;
      r.label = l;
      if (!ok) r.status = STAT_RANGE;
      else if (l == 0) r.status = STAT_ZERO;
      else if (cnt_mem[l] == 0) r.status = STAT_EMPTY;
      else begin
        r.cx = scaled_mean(rs_x, sx_mem[l], cnt_mem[l]);
        r.cy = scaled_mean(rs_y, sy_mem[l], cnt_mem[l]);
        r.cz = scaled_mean(rs_z, sz_mem[l], cnt_mem[l]);
        r.total = cnt_mem[l];
        r.status = STAT_OK;
      end
      centroid_q.insert(centroid_q.size(), r);
    end
  endtask

  task automatic cmp(string nm, logic [SUM_W-1:0] e, logic [SUM_W-1:0] g);
    if (e !== g) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, nm, e, g);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    qres_t e;
    if (rst) begin
      sz_x = 1; sz_y = 1; sz_z = 1;
      rs_x = 65536; rs_y = 65536; rs_z = 65536;
      lbl_lim = 1024;
      wipe_store();
      centroid_q.delete();
      fail_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: unexpected result word, label %0d", $time, out_label);
          fail_count++;
        end else begin
          e = centroid_q.pop_front();
          cmp("out_label", SUM_W'(e.label), SUM_W'(out_label));
          cmp("centroid_x", e.cx, centroid_x);
          cmp("centroid_y", e.cy, centroid_y);
          cmp("centroid_z", e.cz, centroid_z);
          cmp("voxel_total", SUM_W'(e.total), SUM_W'(voxel_total));
          cmp("status", SUM_W'(e.status), SUM_W'(status));
        end
      end
      if (item_valid && item_ready) predict_word(action, label);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X:      sz_x = cfg_data[SIZE_W-1:0];
          REG_SIZE_Y:      sz_y = cfg_data[SIZE_W-1:0];
          REG_SIZE_Z:      sz_z = cfg_data[SIZE_W-1:0];
          REG_RES_X:       rs_x = cfg_data;
          REG_RES_Y:       rs_y = cfg_data;
          REG_RES_Z:       rs_z = cfg_data;
          REG_LABEL_COUNT: lbl_lim = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = centroid_q.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench import lca_pkg::*;;

  logic              clk = 0;
  logic              rst = 1;
  logic              item_valid = 0, item_ready;
  logic [ACT_W-1:0]  action = ACT_ACC;
  logic [LBL_W-1:0]  label = '0;
  logic              result_valid, result_ready = 0;
  logic [LBL_W-1:0]  out_label;
  logic [SUM_W-1:0]  centroid_x, centroid_y, centroid_z;
  logic [CNT_W-1:0]  voxel_total;
  logic [STAT_W-1:0] status;
  logic              cfg_valid = 0, cfg_ready;
  logic [CIDX_W-1:0] cfg_index = REG_SIZE_X;
  logic [CDAT_W-1:0] cfg_data = '0;
  int                fail_count, pending;
  int                cycle = 0;
  bit                calm = 0;
  bit                hold_long = 0;

  localparam int LIMIT = 3000000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  always #6 clk = ~clk;

  label_centroid_accumulator DUT (.*);

  centroid_checker checker_i (.*);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 0;
    @(posedge clk);
    forever begin
      if (hold_long && !held) begin
        held = 1;
        result_ready <= 0;
        repeat (2000) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 0;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk);
      end else begin
        result_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // valid stays up after a word is taken; an idle gap or settle() drops it
  task automatic send_word(logic [ACT_W-1:0] a, logic [LBL_W-1:0] l);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 0;
      n = $urandom_range(1, 5);
      repeat (n) @(posedge clk);
    end
    item_valid <= 1;
    action <= a;
    label <= l;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    item_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (1300) @(posedge clk);
  endtask

  task automatic setup(int x, int y, int z, int rx, int ry, int rz, int lc);
    settle();
    write_reg(REG_SIZE_X, CDAT_W'(x));
    write_reg(REG_SIZE_Y, CDAT_W'(y));
    write_reg(REG_SIZE_Z, CDAT_W'(z));
    write_reg(REG_RES_X, CDAT_W'(rx));
    write_reg(REG_RES_Y, CDAT_W'(ry));
    write_reg(REG_RES_Z, CDAT_W'(rz));
    write_reg(REG_LABEL_COUNT, CDAT_W'(lc));
    cfg_valid <= 0;
  endtask

  // a volume pass mostly over few labels, then a query of each of them and one past
  task automatic random_phase(int voxels, int nlbl);
    int r;
    for (int i = 0; i < voxels; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_word(ACT_QUERY, LBL_W'($urandom_range(0, 1023)));
      else if (r == 1) send_word(ACT_UNUSED, LBL_W'($urandom));
      else if (r == 2) send_word(ACT_ACC, LBL_W'($urandom_range(0, 1023)));
      else send_word(ACT_ACC, LBL_W'($urandom_range(0, nlbl)));
    end
    for (int l = 0; l <= nlbl + 1; l++) send_word(ACT_QUERY, LBL_W'(l));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed: small volume, extremes and special cases
    setup(4, 3, 2, 65536, 16777215, 0, 1024);
    send_word(ACT_QUERY, 0);
    send_word(ACT_QUERY, 5);
    send_word(ACT_QUERY, 1023);
    for (int i = 0; i < 10; i++) send_word(ACT_ACC, LBL_W'((i % 3) + 1));
    send_word(ACT_ACC, 1023);
    send_word(ACT_ACC, 0);
    send_word(ACT_UNUSED, 10'h3ff);
    send_word(ACT_QUERY, 1);
    send_word(ACT_QUERY, 2);
    send_word(ACT_QUERY, 1023);
    send_word(ACT_QUERY, 0);
    send_word(ACT_CLEAR, 0);
    send_word(ACT_QUERY, 1);
    setup(0, 2000, 1, 1, 1, 1, 0);
    send_word(ACT_ACC, 0);
    send_word(ACT_QUERY, 0);
    setup(1024, 1024, 1024, 16777215, 12345, 65536, 1);
    send_word(ACT_ACC, 0);
    send_word(ACT_QUERY, 0);
    send_word(ACT_QUERY, 1);
    // fill the block while the receiver holds off
    send_word(ACT_CLEAR, 0);
    setup(5, 4, 3, 98304, 65536, 40000, 8);
    hold_long = 1;
    for (int i = 0; i < 40; i++) send_word(ACT_ACC, LBL_W'($urandom_range(0, 8)));
    for (int l = 1; l < 6; l++) send_word(ACT_QUERY, LBL_W'(l));
    // random phases across settings
    setup(7, 5, 4, $urandom, $urandom, $urandom, 12);
    random_phase(150, 10);
    setup(3, 1, 9, 65536, 32768, 16777215, 1024);
    random_phase(150, 6);
    setup(1, 6, 2, $urandom, 0, $urandom, 5);
    random_phase(120, 7);
    send_word(ACT_CLEAR, 0);
    calm = 1;
    setup(2, 2, 2, $urandom, $urandom, $urandom, 1023);
    random_phase(80, 4);
    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
